FILE: sv/signed_int_to_decimal_ascii_top_assert.svh
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Checked outside reset.
`define SIDTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SIDTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: sv/sidta_pkg.sv
package sidta_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CharW  = 8;
  localparam int unsigned WeightW = 34;
  localparam int unsigned NumPos = 10;
  localparam int unsigned PosW   = 4;
  localparam int unsigned DigitW = 4;

  localparam logic [PosW-1:0]  POS_TOP    = 4'd9;
  localparam logic [PosW-1:0]  POS_LAST   = 4'd0;
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CharW-1:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic load;
    logic sign;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic in_neg;
    logic out_free;
    logic last_pos;
  } status_t;

  // Decimal weight of a digit position.
  function automatic logic [WeightW-1:0] pow10(input logic [PosW-1:0] pos);
    logic [WeightW-1:0] w;
    unique case (pos)
      4'd0:    w = 34'd1;
      4'd1:    w = 34'd10;
      4'd2:    w = 34'd100;
      4'd3:    w = 34'd1000;
      4'd4:    w = 34'd10000;
      4'd5:    w = 34'd100000;
      4'd6:    w = 34'd1000000;
      4'd7:    w = 34'd10000000;
      4'd8:    w = 34'd100000000;
      4'd9:    w = 34'd1000000000;
      default: w = 34'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: sv/sidta_ctrl.sv
module sidta_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  sidta_pkg::status_t status_i,
  output sidta_pkg::cmd_t    cmd_o
);
  import sidta_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SIGN  = 2'd1;
  localparam logic [1:0] ST_DIGIT = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.sign = 1'b1;
          state_d    = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.last_pos) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/sidta_datapath.sv
module sidta_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic        [sidta_pkg::ValueW-1:0]   value_i,
  input  sidta_pkg::cmd_t                       cmd_i,
  output sidta_pkg::status_t                    status_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic        [sidta_pkg::CharW-1:0]    out_char_o,
  output logic                                  out_last_o
);
  import sidta_pkg::*;

  logic [ValueW-1:0] rem_q, rem_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              started_q, started_d;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  out_char_q, out_char_d;
  logic              out_last_q, out_last_d;

  logic [ValueW-1:0]  mag;
  logic [WeightW-1:0] weight;
  logic [WeightW-1:0] sub;
  logic [DigitW-1:0]  digit;
  logic               emit;
  logic               out_free;

  assign mag      = value_i[ValueW-1] ? (ValueW'(0) - value_i) : value_i;
  assign weight   = pow10(pos_q);
  assign out_free = !out_valid_q || out_ready_i;

  // Digit is the count of multiples of the position weight that fit.
  always_comb begin
    digit = '0;
    sub   = '0;
    for (int d = 1; d <= 9; d++) begin
      if ({2'b00, rem_q} >= weight * WeightW'(d)) begin
        digit = DigitW'(d);
        sub   = weight * WeightW'(d);
      end
    end
  end

  assign emit = (digit != '0) || started_q || (pos_q == POS_LAST);

  always_comb begin
    rem_d       = rem_q;
    pos_d       = pos_q;
    started_d   = started_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    priority if (cmd_i.load) begin
      rem_d     = mag;
      pos_d     = POS_TOP;
      started_d = 1'b0;
    end else if (cmd_i.sign) begin
      out_valid_d = 1'b1;
      out_char_d  = CHAR_MINUS;
      out_last_d  = 1'b0;
    end else if (cmd_i.step) begin
      rem_d = rem_q - sub[ValueW-1:0];
      if (pos_q != POS_LAST) pos_d = pos_q - PosW'(1);
      if (emit) begin
        started_d   = 1'b1;
        out_valid_d = 1'b1;
        out_char_d  = CHAR_ZERO + CharW'(digit);
        out_last_d  = (pos_q == POS_LAST);
      end
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      pos_q       <= POS_LAST;
    end else begin
      out_valid_q <= out_valid_d;
      started_q   <= started_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign status_o.in_neg   = value_i[ValueW-1];
  assign status_o.out_free = out_free;
  assign status_o.last_pos = (pos_q == POS_LAST);

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: sv/signed_int_to_decimal_ascii_top.sv
// Renders each signed 32-bit input as decimal ASCII text, one character per
// output transfer, most significant first: a leading '-' for negative values,
// no leading zeros, "0" for zero, and tlast on the final character. The input
// is taken when the block is idle; the number is then scanned over ten fixed
// decimal positions, one position per cycle while the output register is free
// (a digit compare against the nine multiples of that position's weight),
// after a sign step for negative values. A new input is taken while the last
// character of the previous number still waits.
module signed_int_to_decimal_ascii_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] text_char
  output logic        m_axis_tlast    // is_last
);
  import sidta_pkg::*;

  cmd_t    cmd;
  status_t status;

  sidta_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  sidta_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

FILE: sv/sidta_checker.sv
`include "signed_int_to_decimal_ascii_top_assert.svh"

module sidta_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);
  import sidta_pkg::*;

  `SIDTA_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |=> !m_axis_tvalid, "output valid in reset")

  `SIDTA_ASSERT(a_valid_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "valid dropped")

  `SIDTA_ASSERT(a_data_holds, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled data changed")

  `SIDTA_ASSERT(a_char_legal, m_axis_tvalid |-> (m_axis_tdata == CHAR_MINUS) || ((m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_NINE)), "illegal character")

  `SIDTA_ASSERT(a_minus_not_last, m_axis_tvalid && (m_axis_tdata == CHAR_MINUS) |-> !m_axis_tlast, "sign marked last")

endmodule

bind signed_int_to_decimal_ascii_top sidta_checker u_sidta_checker (.*);
